[rtl/lkvc_pkg.sv]
// Package: sizes, field widths and control types shared by the LRU key/value cache.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int CAP_BITS   = 5;
    localparam int FILL_BITS  = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Register index taken from the word address bit of paddr.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic load;    // take key and value from the neighbor word
        logic valid;   // cell lies inside the filled prefix
    } cell_ctrl_t;

endpackage

[rtl/lkvc_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [KEY_BITS-1:0]   lookup_key;
    logic signed [VALUE_BITS-1:0] store_value;

    modport source (output valid, output kind, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input kind, input lookup_key, input store_value,
                    output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

[rtl/lkvc_cell.sv]
// Cell: one slot of the recency-ordered row, holding a key/value pair and comparing its key.
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [KEY_BITS-1:0]   shift_key,
    input  logic [VALUE_BITS-1:0] shift_value,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  match
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    // Advance the neighbor's pair into this slot when told to.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg   <= shift_key;
            value_reg <= shift_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = ctrl.valid && (key_reg == req_key);

endmodule

[rtl/lru_key_value_cache_top.sv]
// Top level: LRU key/value cache built as a recency-ordered row of cells.
// Result: registered in the cycle after its request word is accepted.
// Throughput: one request word per cycle while the response side is ready; the key compare
//   across all cells and the row shift that reorders recency both finish in the accepting cycle.
// Reset: fill count and output valid clear, capacity returns to 16; no clearing pass,
//   the cell payload is only read inside the filled prefix.
module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    lkvc_req_if.sink              req,
    lkvc_rsp_if.source            rsp
);

    // Cell 0 holds the most recent pair, cell fill-1 the least recent one.
    // Cells at or beyond the fill count are free and their contents are don't-care.

    logic [CAP_BITS-1:0]   capacity_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [FILL_BITS-1:0]  fill_next;

    logic                  rsp_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic                  evicted_reg;
    logic [KEY_BITS-1:0]   evicted_key_reg;

    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0]    cell_match;
    logic [ENTRIES-1:0]    cell_valid;
    logic [ENTRIES-1:0]    cell_lru;
    cell_ctrl_t            cell_ctrl  [ENTRIES];

    logic                  fire;
    logic                  is_put;
    logic                  hit_any;
    logic                  evict;
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]   lru_key;
    logic [VALUE_BITS-1:0] head_value;
    logic [CMP_BITS-1:0]   eff_cap;
    logic [CMP_BITS-1:0]   fill_ext;
    logic                  cfg_write;

    // ---------------------------------------------------------------
    // Configuration port: one register, decoded on the word address bit.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_comb
    begin
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = PDATA_BITS'(capacity_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Zero capacity behaves as one; anything above the row length clamps to it.
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = CMP_BITS'(1);
        end
        else if (CMP_BITS'(capacity_reg) > CMP_BITS'(ENTRIES))
        begin
            eff_cap = CMP_BITS'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_BITS'(capacity_reg);
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the output register frees up in the same cycle it drains.
    // ---------------------------------------------------------------
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_put    = (kind_t'(req.kind) == KIND_PUT);

    // ---------------------------------------------------------------
    // Row-wide lookup: valid prefix, match, hit data and least recent key.
    // ---------------------------------------------------------------
    assign fill_ext = CMP_BITS'(fill_reg);

    always_comb
    begin
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_value = hit_value | cell_value[i];
            end
            if (cell_lru[i])
            begin
                lru_key = lru_key | cell_key[i];
            end
        end
    end

    assign hit_any    = |cell_match;
    assign evict      = fire && is_put && !hit_any && (fill_ext >= eff_cap);
    assign head_value = is_put ? req.store_value : hit_value;

    // A new key grows the fill unless it pushed the least recent pair off the end.
    always_comb
    begin
        fill_next = fill_reg;
        if (fire && is_put && !hit_any && !evict)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end
    end

    // ---------------------------------------------------------------
    // Cell row. On a hit at slot p, cells 0..p shift down by one and the
    // hit pair re-enters at the head. A new put shifts the whole row; the
    // pair that falls past the fill count is the evicted one.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [KEY_BITS-1:0]   shift_key;
        logic [VALUE_BITS-1:0] shift_value;

        assign cell_valid[g] = (FILL_BITS'(g) < fill_reg);

        if (g == ENTRIES - 1)
        begin : g_last
            assign cell_lru[g] = cell_valid[g];
        end
        else
        begin : g_mid
            assign cell_lru[g] = cell_valid[g] && !cell_valid[g+1];
        end

        if (g == 0)
        begin : g_head
            assign shift_key   = req.lookup_key;
            assign shift_value = head_value;
        end
        else
        begin : g_body
            assign shift_key   = cell_key[g-1];
            assign shift_value = cell_value[g-1];
        end

        assign cell_ctrl[g].valid = cell_valid[g];
        assign cell_ctrl[g].load  = fire && ((hit_any && (|cell_match[ENTRIES-1:g]))
                                            || (is_put && !hit_any));

        lkvc_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl[g]),
            .req_key     (req.lookup_key),
            .shift_key   (shift_key),
            .shift_value (shift_value),
            .key         (cell_key[g]),
            .value       (cell_value[g]),
            .match       (cell_match[g])
        );
    end

    // ---------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                capacity_reg <= pwdata[CAP_BITS-1:0];
            end
            fill_reg <= fill_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next accepted request replaces it.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg         <= hit_any;
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? lru_key : '0;
            if (is_put)
            begin
                read_value_reg <= '0;
            end
            else if (hit_any)
            begin
                read_value_reg <= hit_value;
            end
            else
            begin
                read_value_reg <= '1;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.evicted     = evicted_reg;
    assign rsp.evicted_key = evicted_key_reg;

endmodule
